@@ rtl/core/bb3_pkg.sv @@
// bb3_pkg: shared types, sizes and helpers for the 3x3 box blur
package bb3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // register file
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
    localparam logic [CFG_W-1:0]     RST_FRAME_WIDTH  = 11'd800;
    localparam logic [CFG_W-1:0]     RST_FRAME_HEIGHT = 11'd600;

    // counters
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_OUT_W = $clog2(MAX_HEIGHT);
    localparam int ROW_IN_W  = $clog2(MAX_HEIGHT + 2);
    localparam int CMP_W     = 16;

    // pixels and sums
    localparam int CH_W  = 8;
    localparam int PIX_W = 3 * CH_W;
    localparam int SUM_W = 12;
    localparam int WORD_W = 32;
    localparam logic [CH_W-1:0] ALPHA = 8'hFF;

    // divide by 9 as multiply by round-up reciprocal, exact for sums below 2^12
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_9 = 13'd7282;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [SUM_W-1:0] t_sum;

    // per-item control carried from the counter stage to the window stage
    typedef struct packed {
        logic has_out;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_s1_ctl;

    function automatic logic [CH_W-1:0] div9(input t_sum s);
        logic [SUM_W+RECIP_W-1:0] p;
        p = {{RECIP_W{1'b0}}, s} * {{SUM_W{1'b0}}, RECIP_9};
        return p[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    endfunction

endpackage

@@ rtl/core/box_blur_3x3_rgb.sv @@
// box_blur_3x3_rgb: streaming 3x3 box blur over one raster RGB frame
//
// Takes one pixel (or flush item) per clock and gives one blurred RGBA word per clock once
// the window is primed, unless o_stall or i_stall holds the flow; the result for pixel q
// leaves after pixel q+W+1 is transferred, so W+1 flush items after the last pixel drain
// the frame. A result passes the line-store read, which lands at the transfer edge, then
// the window update and neighbourhood sum, then the divide by 9 into the output register.
// Both line stores sit in a single 1024 x 48 memory that is read and written back
// once per pixel, and that one port pair sets the rate. A skid register behind the output
// register keeps input transfers going while one result waits; a second waiting result stalls
// the input. The line stores need no clearing after reset.
// Writing frame_width or frame_height restarts the frame; write them only while idle.
module box_blur_3x3_rgb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration
    input  logic                            i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]       i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_action,
    input  logic [bb3_pkg::CH_W-1:0]        i_red_in,
    input  logic [bb3_pkg::CH_W-1:0]        i_green_in,
    input  logic [bb3_pkg::CH_W-1:0]        i_blue_in,
    // output channel
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [bb3_pkg::WORD_W-1:0]      o_blurred_word,
    output logic                            o_last_in_frame
);

    localparam int LS_W = 2 * bb3_pkg::PIX_W;

    // configuration registers
    logic [bb3_pkg::CFG_W-1:0] r_frame_width;
    logic [bb3_pkg::CFG_W-1:0] r_frame_height;
    logic [bb3_pkg::CFG_W-1:0] w_eff;
    logic [bb3_pkg::CFG_W-1:0] h_eff;

    // counters
    logic [bb3_pkg::COL_W-1:0]     r_in_col, n_in_col;
    logic [bb3_pkg::ROW_IN_W-1:0]  r_in_row, n_in_row;
    logic [bb3_pkg::COL_W-1:0]     r_out_col, n_out_col;
    logic [bb3_pkg::ROW_OUT_W-1:0] r_out_row, n_out_row;

    // line stores: upper half is the row two above, lower half the row one above
    logic [LS_W-1:0] ls_mem [bb3_pkg::MAX_WIDTH];
    logic [LS_W-1:0] r_rd_data;
    logic [LS_W-1:0] r_fwd_data;
    logic            r_s1_fwd;

    // stage 1
    logic                       r_s1_valid;
    bb3_pkg::t_s1_ctl           r_s1_ctl;
    bb3_pkg::t_pix              r_s1_pix;
    logic [bb3_pkg::COL_W-1:0]  r_s1_addr;

    // window, [row top/mid/bottom][col left/centre/right]
    bb3_pkg::t_pix r_win [3][3];
    bb3_pkg::t_pix n_win [3][3];

    // stage 2
    logic          r_s2_valid;
    logic          r_s2_last;
    bb3_pkg::t_sum r_s2_sum [3];
    bb3_pkg::t_sum n_sum [3];

    // output and skid
    logic                         r_out_valid;
    logic [bb3_pkg::WORD_W-1:0]   r_out_word;
    logic                         r_out_last;
    logic                         r_skid_valid;
    logic [bb3_pkg::WORD_W-1:0]   r_skid_word;
    logic                         r_skid_last;

    logic                         adv;
    logic                         accept;
    logic                         take;
    bb3_pkg::t_s1_ctl             s0_ctl;
    logic                         pix_live;
    logic                         col_wrap;
    bb3_pkg::t_pix                s0_pix;
    logic [LS_W-1:0]              ls_rd;
    bb3_pkg::t_pix                top_pix;
    bb3_pkg::t_pix                mid_pix;
    logic [LS_W-1:0]              ls_wr;
    logic [bb3_pkg::WORD_W-1:0]   s2_word;
    logic [2:0]                   row_ok;
    logic [2:0]                   col_ok;

    assign adv     = !r_skid_valid;
    assign o_stall = r_skid_valid;
    assign accept  = i_valid && !r_skid_valid;
    assign take    = r_out_valid && !i_stall;

    // effective frame size
    always_comb begin
        if (r_frame_width == '0) begin
            w_eff = bb3_pkg::CFG_W'(1);
        end else if (int'(r_frame_width) > bb3_pkg::MAX_WIDTH) begin
            w_eff = bb3_pkg::CFG_W'(bb3_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h_eff = bb3_pkg::CFG_W'(1);
        end else if (int'(r_frame_height) > bb3_pkg::MAX_HEIGHT) begin
            h_eff = bb3_pkg::CFG_W'(bb3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // stage 0: position bookkeeping at the input transfer
    always_comb begin
        col_wrap = (bb3_pkg::CMP_W'(r_in_col) + bb3_pkg::CMP_W'(1))
                   >= bb3_pkg::CMP_W'(w_eff);
        pix_live = !i_action && (bb3_pkg::CMP_W'(r_in_row) < bb3_pkg::CMP_W'(h_eff));
        s0_pix   = pix_live ? {i_red_in, i_green_in, i_blue_in} : '0;

        s0_ctl.has_out  = (bb3_pkg::CMP_W'(r_in_row) >= bb3_pkg::CMP_W'(2)) ||
                          ((r_in_row == bb3_pkg::ROW_IN_W'(1)) && (r_in_col != '0));
        s0_ctl.top_ok   = r_out_row != '0;
        s0_ctl.bot_ok   = (bb3_pkg::CMP_W'(r_out_row) + bb3_pkg::CMP_W'(1))
                          < bb3_pkg::CMP_W'(h_eff);
        s0_ctl.left_ok  = r_out_col != '0;
        s0_ctl.right_ok = (bb3_pkg::CMP_W'(r_out_col) + bb3_pkg::CMP_W'(1))
                          < bb3_pkg::CMP_W'(w_eff);
        s0_ctl.last     = !s0_ctl.bot_ok && !s0_ctl.right_ok;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (i_cfg_we) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (accept) begin
            if (s0_ctl.has_out && s0_ctl.last) begin
                // frame done, next item is pixel 0 of a new frame
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                if (s0_ctl.has_out) begin
                    if (s0_ctl.right_ok) begin
                        n_out_col = r_out_col + bb3_pkg::COL_W'(1);
                    end else begin
                        n_out_col = '0;
                        n_out_row = r_out_row + bb3_pkg::ROW_OUT_W'(1);
                    end
                end
                if (col_wrap) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + bb3_pkg::ROW_IN_W'(1);
                end else begin
                    n_in_col = r_in_col + bb3_pkg::COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= bb3_pkg::RST_FRAME_WIDTH;
            r_frame_height <= bb3_pkg::RST_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bb3_pkg::REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                bb3_pkg::REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // stage 1: line-store data, forwarding when the previous item wrote the same column
    assign ls_rd   = r_s1_fwd ? r_fwd_data : r_rd_data;
    assign top_pix = ls_rd[LS_W-1:bb3_pkg::PIX_W];
    assign mid_pix = ls_rd[bb3_pkg::PIX_W-1:0];
    assign ls_wr   = {mid_pix, r_s1_pix};

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd_data <= ls_mem[r_in_col];
        end
        if (r_s1_valid && adv) begin
            ls_mem[r_s1_addr] <= ls_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_fwd   <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= accept;
            r_s1_fwd   <= accept && r_s1_valid && (r_s1_addr == r_in_col);
        end
        if (accept) begin
            r_s1_ctl   <= s0_ctl;
            r_s1_pix   <= s0_pix;
            r_s1_addr  <= r_in_col;
            r_fwd_data <= ls_wr;
        end
    end

    // shifted window and masked neighbourhood sums
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = top_pix;
        n_win[1][2] = mid_pix;
        n_win[2][2] = r_s1_pix;

        row_ok = {r_s1_ctl.bot_ok, 1'b1, r_s1_ctl.top_ok};
        col_ok = {r_s1_ctl.right_ok, 1'b1, r_s1_ctl.left_ok};
        for (int c = 0; c < 3; c++) begin
            n_sum[c] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (row_ok[i] && col_ok[j]) begin
                    n_sum[0] = n_sum[0] + bb3_pkg::SUM_W'(n_win[i][j][23:16]);
                    n_sum[1] = n_sum[1] + bb3_pkg::SUM_W'(n_win[i][j][15:8]);
                    n_sum[2] = n_sum[2] + bb3_pkg::SUM_W'(n_win[i][j][7:0]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= '0;
                end
            end
        end else if (r_s1_valid && adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[i][j] <= (r_s1_ctl.has_out && r_s1_ctl.last) ? '0 : n_win[i][j];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= r_s1_valid && r_s1_ctl.has_out;
        end
        if (adv && r_s1_valid) begin
            r_s2_last <= r_s1_ctl.last;
            for (int c = 0; c < 3; c++) begin
                r_s2_sum[c] <= n_sum[c];
            end
        end
    end

    // stage 2: divide by 9 and pack
    assign s2_word = {bb3_pkg::div9(r_s2_sum[0]), bb3_pkg::div9(r_s2_sum[1]),
                      bb3_pkg::div9(r_s2_sum[2]), bb3_pkg::ALPHA};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                if (take) begin
                    r_out_valid  <= 1'b1;
                    r_out_word   <= r_skid_word;
                    r_out_last   <= r_skid_last;
                    r_skid_valid <= 1'b0;
                end
            end else if (r_s2_valid) begin
                if (!r_out_valid || take) begin
                    r_out_valid <= 1'b1;
                    r_out_word  <= s2_word;
                    r_out_last  <= r_s2_last;
                end else begin
                    // output is held, park the new result
                    r_skid_valid <= 1'b1;
                    r_skid_word  <= s2_word;
                    r_skid_last  <= r_s2_last;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_blurred_word  = r_out_word;
    assign o_last_in_frame = r_out_last;

endmodule

@@ rtl/core/bb3_checker.sv @@
// bb3_checker: port-level assertions for box_blur_3x3_rgb, bound to the top level
module bb3_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [bb3_pkg::WORD_W-1:0]      o_blurred_word,
    input logic                            o_last_in_frame
);

    // reset empties the output side
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_blurred_word) && $stable(o_last_in_frame))
        else $error("stalled result changed");

    // input stalls only while a result is waiting at the output
    a_stall_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no result pending");

    // one output transfer frees the input side
    a_stall_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall)
        else $error("input still stalled after output transfer");

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (.*);
